FILE: hdl/owbt_pkg.sv
package owbt_pkg;

   localparam int POS_BITS    = 48;
   localparam int TAG_BITS    = 4;
   localparam int TOKEN_SLOTS = 1 << TAG_BITS;
   localparam int SHOT_BITS   = 4;
   localparam int SHOT_SLOTS  = 1 << SHOT_BITS;
   localparam int FRAME_BITS  = 21;
   localparam int OVL_BITS    = 20;
   localparam int CSR_BITS    = 2;

   localparam logic [2:0] FUNC_WRITE = 3'd0;
   localparam logic [2:0] FUNC_READ  = 3'd1;
   localparam logic [2:0] FUNC_WDONE = 3'd2;
   localparam logic [2:0] FUNC_RDONE = 3'd3;
   localparam logic [2:0] FUNC_CLOSE = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_WAIT     = 3'd1;
   localparam logic [2:0] ST_TOOLARGE = 3'd2;
   localparam logic [2:0] ST_CLOSED   = 3'd3;
   localparam logic [2:0] ST_DEADLOCK = 3'd4;
   localparam logic [2:0] ST_SHORT    = 3'd5;

   localparam logic [CSR_BITS-1:0] CSR_BUFFER  = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_WINDOW  = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_OVERLAP = 2'd2;

   typedef struct packed {
      logic [2:0]            func;
      logic [FRAME_BITS-1:0] write_frames;
      logic                  ends_shot;
      logic [TAG_BITS-1:0]   done_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [TAG_BITS-1:0]   token_tag;
      logic [POS_BITS-1:0]   start_pos;
      logic [FRAME_BITS-1:0] span_frames;
      logic [OVL_BITS-1:0]   span_overlap;
      logic                  is_shot_start;
      logic                  is_shot_end;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic ws;
      logic we;
      logic rs;
      logic commit;
      logic retire;
   } cmd_type;

   typedef struct packed {
      logic retire_evt;
      logic retire_more;
   } sts_type;

endpackage

FILE: hdl/owbt_ctrl.sv
module owbt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              csr_ready,
   output owbt_pkg::cmd_type cmd,
   input  owbt_pkg::sts_type sts
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_WS   = 8'b00000010,
      S_WE   = 8'b00000100,
      S_RS   = 8'b00001000,
      S_DEC  = 8'b00010000,
      S_RTRD = 8'b00100000,
      S_RTUP = 8'b01000000,
      S_RSP  = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_WS;
         S_WS:   state_in = S_WE;
         S_WE:   state_in = S_RS;
         S_RS:   state_in = S_DEC;
         S_DEC:  state_in = sts.retire_evt ? S_RTRD : S_RSP;
         S_RTRD: state_in = S_RTUP;
         S_RTUP: state_in = sts.retire_more ? S_RTRD : S_RSP;
         S_RSP:  if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = (state_ff == S_RSP);
   assign csr_ready  = (state_ff == S_IDLE);
   assign cmd.accept = (state_ff == S_IDLE) && req_valid;
   assign cmd.ws     = (state_ff == S_WS);
   assign cmd.we     = (state_ff == S_WE);
   assign cmd.rs     = (state_ff == S_RS);
   assign cmd.commit = (state_ff == S_DEC);
   assign cmd.retire = (state_ff == S_RTUP);

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("response shown while taking requests");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("response dropped");
   a_dec_path: assert property (@(posedge clock) disable iff (reset)
      cmd.ws |=> cmd.we ##1 cmd.rs ##1 cmd.commit) else $error("stage order");

endmodule

FILE: hdl/owbt_dp.sv
module owbt_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  owbt_pkg::cmd_type                  cmd,
   output owbt_pkg::sts_type                  sts,
   input  owbt_pkg::req_type                  req_data,
   output owbt_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [owbt_pkg::CSR_BITS-1:0]      csr_index,
   input  logic [owbt_pkg::FRAME_BITS-1:0]    csr_data
);

   localparam int PB = owbt_pkg::POS_BITS;
   localparam int FB = owbt_pkg::FRAME_BITS;
   localparam int OB = owbt_pkg::OVL_BITS;
   localparam int TB = owbt_pkg::TAG_BITS;
   localparam int SB = owbt_pkg::SHOT_BITS;

   logic [FB-1:0] buf_ff, win_ff;
   logic [OB-1:0] ovl_ff;

   logic [PB-1:0] wp_ff, wp_in, wd_ff, wd_in, rp_ff, rp_in, rd_ff, rd_in;
   logic          closed_ff, closed_in;

   logic [SB-1:0] sh_head_ff, sh_head_in;
   logic [SB:0]   sh_count_ff, sh_count_in;
   logic [owbt_pkg::SHOT_SLOTS-1:0] sh_endv_ff, sh_endv_in;
   logic [TB-1:0] wt_head_ff, wt_head_in, rt_head_ff, rt_head_in;
   logic [TB:0]   wt_count_ff, wt_count_in, rt_count_ff, rt_count_in;
   logic [owbt_pkg::TOKEN_SLOTS-1:0] wt_done_ff, wt_done_in, rt_done_ff, rt_done_in;

   logic [PB-1:0] sh_start_mem [owbt_pkg::SHOT_SLOTS];
   logic [PB-1:0] sh_end_mem   [owbt_pkg::SHOT_SLOTS];
   logic [FB-1:0] wt_size_mem  [owbt_pkg::TOKEN_SLOTS];
   logic [PB-1:0] rt_start_mem [owbt_pkg::TOKEN_SLOTS];
   logic [PB-1:0] rt_end_mem   [owbt_pkg::TOKEN_SLOTS];

   logic [PB-1:0] shh_start_ff, shb_start_ff, shh_end_ff, shb_end_ff;
   logic [FB-1:0] wth_size_ff;
   logic [PB-1:0] rth_start_ff, rth_end_ff;

   owbt_pkg::req_type req_ff;
   owbt_pkg::rsp_type rsp_ff, rsp_in;

   logic [PB-1:0] s_ff;
   logic [PB:0]   wsum_ff, wlim_ff, rlim_ff, e_ff, lim_ff, nearb_ff;
   logic          starts_ff, ready_ff, wready_ff, first_ff, last_ff, short_ff;
   logic [FB-1:0] size_ff;
   logic [OB-1:0] ovlr_ff;

   logic [SB-1:0] sh_back, sh_new;
   logic [PB-1:0] lo, s_calc, near, base, wpn;
   logic [PB:0]   e0, e_diff;
   logic [PB-1:0] r_diff;
   logic [FB-1:0] adv;
   logic [TB-1:0] wt_slot, rt_slot, wt_off, rt_off;
   logic          wt_busy, rt_busy;
   logic [SB-1:0] sh_wr_addr;
   logic          sh_start_we, sh_end_we, wt_we, rt_we;
   logic [PB-1:0] sh_start_wd, sh_end_wd;

   assign sh_back = sh_head_ff + sh_count_ff[SB-1:0] - SB'(1);
   assign sh_new  = sh_head_ff + sh_count_ff[SB-1:0];
   assign wt_slot = wt_head_ff + wt_count_ff[TB-1:0];
   assign rt_slot = rt_head_ff + rt_count_ff[TB-1:0];
   assign wt_off  = req_ff.done_tag - wt_head_ff;
   assign rt_off  = req_ff.done_tag - rt_head_ff;
   assign wt_busy = {1'b0, wt_off} < wt_count_ff;
   assign rt_busy = {1'b0, rt_off} < rt_count_ff;

   assign lo     = (rp_ff > PB'(ovl_ff)) ? rp_ff - PB'(ovl_ff) : '0;
   assign s_calc = (shh_start_ff > lo) ? shh_start_ff : lo;
   assign e0     = {1'b0, s_ff} + (PB+1)'(win_ff);
   assign near   = (rt_count_ff != '0) ? rth_start_ff :
                   (sh_count_ff == '0) ? rp_ff : s_ff;
   assign e_diff = e_ff - {1'b0, s_ff};
   assign r_diff = rp_ff - s_ff;
   assign wpn    = wsum_ff[PB-1:0];
   assign base   = starts_ff ? wp_ff : shb_start_ff;
   assign adv    = (size_ff > FB'(ovlr_ff)) ? size_ff - FB'(ovlr_ff) : '0;

   assign sts.retire_evt  = (req_ff.func == owbt_pkg::FUNC_WDONE) ||
                            (req_ff.func == owbt_pkg::FUNC_RDONE);
   assign sts.retire_more = (req_ff.func == owbt_pkg::FUNC_WDONE) ?
                            (wt_count_ff != '0 && wt_done_ff[wt_head_ff]) :
                            (rt_count_ff != '0 && rt_done_ff[rt_head_ff]);

   always_comb begin
      wp_in = wp_ff; wd_in = wd_ff; rp_in = rp_ff; rd_in = rd_ff;
      closed_in = closed_ff;
      sh_head_in = sh_head_ff; sh_count_in = sh_count_ff; sh_endv_in = sh_endv_ff;
      wt_head_in = wt_head_ff; wt_count_in = wt_count_ff; wt_done_in = wt_done_ff;
      rt_head_in = rt_head_ff; rt_count_in = rt_count_ff; rt_done_in = rt_done_ff;
      rsp_in = rsp_ff;
      sh_start_we = 1'b0; sh_end_we = 1'b0; wt_we = 1'b0; rt_we = 1'b0;
      sh_wr_addr = starts_ff ? sh_new : sh_back;
      sh_start_wd = wp_ff;
      sh_end_wd = wpn;
      if (cmd.commit) begin
         rsp_in = '0;
         unique case (req_ff.func)
            owbt_pkg::FUNC_WRITE: begin
               priority if ((FB+1)'(req_ff.write_frames) > (FB+1)'(buf_ff)) begin
                  rsp_in.status = owbt_pkg::ST_TOOLARGE;
               end else if (wsum_ff > wlim_ff) begin
                  rsp_in.status = owbt_pkg::ST_WAIT;
               end else if (closed_ff) begin
                  rsp_in.status = owbt_pkg::ST_CLOSED;
               end else if (!wready_ff) begin
                  if (rt_count_ff == '0 && wt_count_ff == '0 && !ready_ff) begin
                     closed_in = 1'b1;
                     rsp_in.status = owbt_pkg::ST_DEADLOCK;
                  end else begin
                     rsp_in.status = owbt_pkg::ST_WAIT;
                  end
               end else if (wt_count_ff == (TB+1)'(owbt_pkg::TOKEN_SLOTS) ||
                            (starts_ff && sh_count_ff == (SB+1)'(owbt_pkg::SHOT_SLOTS))) begin
                  rsp_in.status = owbt_pkg::ST_WAIT;
               end else begin
                  if (starts_ff) begin
                     sh_start_we = 1'b1;
                     sh_endv_in[sh_new] = 1'b0;
                     sh_count_in = sh_count_ff + 1'b1;
                  end
                  if (req_ff.ends_shot) begin
                     sh_end_we = 1'b1;
                     sh_endv_in[sh_wr_addr] = 1'b1;
                  end
                  wt_we = 1'b1;
                  wt_done_in[wt_slot] = 1'b0;
                  wt_count_in = wt_count_ff + 1'b1;
                  wp_in = wpn;
                  rsp_in.status = (req_ff.ends_shot && short_ff) ?
                                  owbt_pkg::ST_SHORT : owbt_pkg::ST_OK;
                  rsp_in.token_tag = wt_slot;
                  rsp_in.start_pos = wp_ff;
                  rsp_in.span_frames = req_ff.write_frames;
                  rsp_in.is_shot_start = starts_ff;
                  rsp_in.is_shot_end = req_ff.ends_shot;
               end
            end
            owbt_pkg::FUNC_READ: begin
               priority if (!ready_ff) begin
                  rsp_in.status = (closed_ff && wt_count_ff == '0) ?
                                  owbt_pkg::ST_CLOSED : owbt_pkg::ST_WAIT;
               end else if (rt_count_ff == (TB+1)'(owbt_pkg::TOKEN_SLOTS)) begin
                  rsp_in.status = owbt_pkg::ST_WAIT;
               end else begin
                  if (last_ff) begin
                     sh_head_in = sh_head_ff + 1'b1;
                     sh_count_in = sh_count_ff - 1'b1;
                  end
                  rt_we = 1'b1;
                  rt_done_in[rt_slot] = 1'b0;
                  rt_count_in = rt_count_ff + 1'b1;
                  rp_in = rp_ff + PB'(adv);
                  rsp_in.status = owbt_pkg::ST_OK;
                  rsp_in.token_tag = rt_slot;
                  rsp_in.start_pos = s_ff;
                  rsp_in.span_frames = size_ff;
                  rsp_in.span_overlap = ovlr_ff;
                  rsp_in.is_shot_start = first_ff;
                  rsp_in.is_shot_end = last_ff;
               end
            end
            owbt_pkg::FUNC_WDONE: begin
               if (wt_busy) wt_done_in[req_ff.done_tag] = 1'b1;
               rsp_in.token_tag = req_ff.done_tag;
            end
            owbt_pkg::FUNC_RDONE: begin
               if (rt_busy) rt_done_in[req_ff.done_tag] = 1'b1;
               rsp_in.token_tag = req_ff.done_tag;
            end
            owbt_pkg::FUNC_CLOSE: closed_in = 1'b1;
            default: ;
         endcase
      end
      if (cmd.retire && sts.retire_more) begin
         if (req_ff.func == owbt_pkg::FUNC_WDONE) begin
            wd_in = wd_ff + PB'(wth_size_ff);
            wt_done_in[wt_head_ff] = 1'b0;
            wt_head_in = wt_head_ff + 1'b1;
            wt_count_in = wt_count_ff - 1'b1;
         end else begin
            rd_in = rth_end_ff;
            rt_done_in[rt_head_ff] = 1'b0;
            rt_head_in = rt_head_ff + 1'b1;
            rt_count_in = rt_count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= FB'(64); win_ff <= FB'(1); ovl_ff <= '0;
         wp_ff <= '0; wd_ff <= '0; rp_ff <= '0; rd_ff <= '0;
         closed_ff <= 1'b0;
         sh_head_ff <= '0; sh_count_ff <= '0; sh_endv_ff <= '0;
         wt_head_ff <= '0; wt_count_ff <= '0; wt_done_ff <= '0;
         rt_head_ff <= '0; rt_count_ff <= '0; rt_done_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               owbt_pkg::CSR_BUFFER:  buf_ff <= csr_data;
               owbt_pkg::CSR_WINDOW:  win_ff <= csr_data;
               owbt_pkg::CSR_OVERLAP: ovl_ff <= csr_data[OB-1:0];
               default: ;
            endcase
         end
         wp_ff <= wp_in; wd_ff <= wd_in; rp_ff <= rp_in; rd_ff <= rd_in;
         closed_ff <= closed_in;
         sh_head_ff <= sh_head_in; sh_count_ff <= sh_count_in; sh_endv_ff <= sh_endv_in;
         wt_head_ff <= wt_head_in; wt_count_ff <= wt_count_in; wt_done_ff <= wt_done_in;
         rt_head_ff <= rt_head_in; rt_count_ff <= rt_count_in; rt_done_ff <= rt_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sh_start_we) sh_start_mem[sh_new] <= sh_start_wd;
      if (sh_end_we)   sh_end_mem[sh_wr_addr] <= sh_end_wd;
      if (wt_we)       wt_size_mem[wt_slot] <= req_ff.write_frames;
      if (rt_we) begin
         rt_start_mem[rt_slot] <= s_ff;
         rt_end_mem[rt_slot]   <= s_ff + PB'(size_ff);
      end
      shh_start_ff <= sh_start_mem[sh_head_ff];
      shb_start_ff <= sh_start_mem[sh_back];
      shh_end_ff   <= sh_end_mem[sh_head_ff];
      shb_end_ff   <= sh_end_mem[sh_back];
      wth_size_ff  <= wt_size_mem[wt_head_ff];
      rth_start_ff <= rt_start_mem[rt_head_ff];
      rth_end_ff   <= rt_end_mem[rt_head_ff];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.accept) req_ff <= req_data;
      if (cmd.ws) begin
         s_ff      <= s_calc;
         wsum_ff   <= {1'b0, wp_ff} + (PB+1)'(req_ff.write_frames);
         wlim_ff   <= {1'b0, wd_ff} + (PB+1)'(buf_ff);
         rlim_ff   <= {1'b0, rd_ff} + (PB+1)'(buf_ff);
         starts_ff <= (sh_count_ff == '0) || (sh_endv_ff[sh_back] && wp_ff == shb_end_ff);
      end
      if (cmd.we) begin
         e_ff     <= (sh_endv_ff[sh_head_ff] && {1'b0, shh_end_ff} < e0) ?
                     {1'b0, shh_end_ff} : e0;
         lim_ff   <= (rlim_ff < {1'b0, wd_ff}) ? rlim_ff : {1'b0, wd_ff};
         nearb_ff <= {1'b0, near} + (PB+1)'(buf_ff);
      end
      if (cmd.rs) begin
         ready_ff  <= (sh_count_ff != '0) && (e_ff <= lim_ff);
         wready_ff <= wsum_ff <= nearb_ff;
         size_ff   <= (e_ff > {1'b0, s_ff}) ? e_diff[FB-1:0] : '0;
         ovlr_ff   <= (rp_ff > s_ff) ? r_diff[OB-1:0] : '0;
         first_ff  <= s_ff == shh_start_ff;
         last_ff   <= sh_endv_ff[sh_head_ff] &&
                      (((e_ff > {1'b0, s_ff}) ? e_ff : {1'b0, s_ff}) == {1'b0, shh_end_ff});
         short_ff  <= (wpn >= base) && ((wpn - base) <= PB'(ovl_ff));
      end
   end

   assign rsp_data = rsp_ff;

   a_wt_cap: assert property (@(posedge clock) disable iff (reset)
      wt_count_ff <= (TB+1)'(owbt_pkg::TOKEN_SLOTS)) else $error("write tokens overflow");
   a_sh_cap: assert property (@(posedge clock) disable iff (reset)
      sh_count_ff <= (SB+1)'(owbt_pkg::SHOT_SLOTS)) else $error("shot queue overflow");
   a_grant: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && wt_we) |=> wt_count_ff == $past(wt_count_ff) + 1'b1)
      else $error("write grant lost");

endmodule

FILE: hdl/overlapped_window_buffer_tokens.sv
// Sequence: an accepted request passes states WS, WE, RS and DEC; its response
//   is valid in RSP. A done event walks RTRD/RTUP per retired token (up to 16).
// Throughput: one request at a time, set by the staged position compare path and
//   the in-order retire walk; the next is taken once the response is taken.
// Reset (synchronous): clears positions, token and shot queues, closed flag,
//   and loads buffer 64, window 1, overlap 0.
module overlapped_window_buffer_tokens (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  owbt_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output owbt_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [owbt_pkg::CSR_BITS-1:0]   csr_index,
   input  logic [owbt_pkg::FRAME_BITS-1:0] csr_data
);

   owbt_pkg::cmd_type cmd;
   owbt_pkg::sts_type sts;

   owbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   owbt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int  LIMIT    = 3000000;
   localparam int  DRAIN    = 60;
   localparam bit [63:0] PMASK = 64'h0000_FFFF_FFFF_FFFF;
   localparam int  TAGW     = owbt_pkg::TAG_BITS;
   localparam int  POSW     = owbt_pkg::POS_BITS;
   localparam int  FRW      = owbt_pkg::FRAME_BITS;
   localparam int  OVW      = owbt_pkg::OVL_BITS;
   localparam int  CSRW     = owbt_pkg::CSR_BITS;
   localparam int  TSLOTS   = owbt_pkg::TOKEN_SLOTS;
   localparam int  SSLOTS   = owbt_pkg::SHOT_SLOTS;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   owbt_pkg::req_type     req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   owbt_pkg::rsp_type     rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSRW-1:0]       csr_index = owbt_pkg::CSR_BUFFER;
   logic [FRW-1:0]        csr_data = '0;

   int unsigned       cycles = 0;
   int unsigned       errors = 0;
   int unsigned       send_idle_pct = 0;
   int unsigned       stall_pct = 0;
   int unsigned       hold_len = 0;
   owbt_pkg::rsp_type span_q[$];

   bit [63:0] cfg_buffer, cfg_window, cfg_overlap;
   bit [63:0] pos_wr, pos_wr_done, pos_rd, pos_rd_done;
   bit        is_closed;
   bit [63:0] shot_lo[SSLOTS], shot_hi[SSLOTS];
   bit        shot_hi_known[SSLOTS];
   int        shot_head, shot_cnt;
   bit [63:0] wtok_start[TSLOTS], wtok_size[TSLOTS];
   bit        wtok_done[TSLOTS];
   int        wtok_head, wtok_cnt;
   bit [63:0] rtok_start[TSLOTS], rtok_size[TSLOTS];
   bit        rtok_done[TSLOTS];
   int        rtok_head, rtok_cnt;

   overlapped_window_buffer_tokens i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_len > 0) begin
         rsp_stall <= 1'b1;
         hold_len = hold_len - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic bit [63:0] window_lo();
      bit [63:0] lo;
      lo = pos_rd > cfg_overlap ? pos_rd - cfg_overlap : 64'd0;
      return shot_lo[shot_head] > lo ? shot_lo[shot_head] : lo;
   endfunction

   function automatic bit [63:0] window_hi(bit [63:0] s);
      bit [63:0] e;
      e = s + cfg_window;
      if (shot_hi_known[shot_head] && shot_hi[shot_head] < e) e = shot_hi[shot_head];
      return e;
   endfunction

   function automatic bit frames_ready();
      bit [63:0] lim;
      if (shot_cnt == 0) return 1'b0;
      lim = pos_rd_done + cfg_buffer;
      if (pos_wr_done < lim) lim = pos_wr_done;
      return window_hi(window_lo()) <= lim;
   endfunction

   function automatic owbt_pkg::rsp_type grant_write(bit [63:0] n, bit ends, bit apply);
      owbt_pkg::rsp_type o;
      bit [63:0]         near, start;
      int                slot, back;
      bit                starts;
      o = '0;
      if (n > cfg_buffer) begin
         o.status = owbt_pkg::ST_TOOLARGE;
         return o;
      end
      if (pos_wr + n > pos_wr_done + cfg_buffer) begin
         o.status = owbt_pkg::ST_WAIT;
         return o;
      end
      if (is_closed) begin
         o.status = owbt_pkg::ST_CLOSED;
         return o;
      end
      if (rtok_cnt != 0) near = rtok_start[rtok_head];
      else if (shot_cnt == 0) near = pos_rd;
      else near = window_lo();
      if (!(pos_wr + n <= near + cfg_buffer)) begin
         if (rtok_cnt == 0 && wtok_cnt == 0 && !frames_ready()) begin
            if (apply) is_closed = 1'b1;
            o.status = owbt_pkg::ST_DEADLOCK;
         end else begin
            o.status = owbt_pkg::ST_WAIT;
         end
         return o;
      end
      back = (shot_head + shot_cnt + SSLOTS - 1) % SSLOTS;
      starts = shot_cnt == 0 || (shot_hi_known[back] && pos_wr == shot_hi[back]);
      if (wtok_cnt >= TSLOTS || (starts && shot_cnt >= SSLOTS)) begin
         o.status = owbt_pkg::ST_WAIT;
         return o;
      end
      o.status = owbt_pkg::ST_OK;
      if (!apply) return o;
      start = pos_wr;
      if (starts) begin
         back = (shot_head + shot_cnt) % SSLOTS;
         shot_lo[back] = start;
         shot_hi[back] = 0;
         shot_hi_known[back] = 1'b0;
         shot_cnt++;
      end
      slot = (wtok_head + wtok_cnt) % TSLOTS;
      wtok_start[slot] = start;
      wtok_size[slot] = n;
      wtok_done[slot] = 1'b0;
      wtok_cnt++;
      pos_wr = (pos_wr + n) & PMASK;
      if (ends) begin
         shot_hi[back] = pos_wr;
         shot_hi_known[back] = 1'b1;
         if (pos_wr - shot_lo[back] <= cfg_overlap) o.status = owbt_pkg::ST_SHORT;
      end
      o.token_tag = TAGW'(slot);
      o.start_pos = POSW'(start);
      o.span_frames = FRW'(n);
      o.is_shot_start = starts;
      o.is_shot_end = ends;
      return o;
   endfunction

   function automatic owbt_pkg::rsp_type grant_read();
      owbt_pkg::rsp_type o;
      bit [63:0]         s, e, size, ovl, adv;
      int                slot;
      bit                first, last;
      o = '0;
      if (!frames_ready()) begin
         o.status = (is_closed && wtok_cnt == 0) ? owbt_pkg::ST_CLOSED : owbt_pkg::ST_WAIT;
         return o;
      end
      if (rtok_cnt >= TSLOTS) begin
         o.status = owbt_pkg::ST_WAIT;
         return o;
      end
      s = window_lo();
      e = window_hi(s);
      size = e > s ? e - s : 64'd0;
      ovl = pos_rd > s ? pos_rd - s : 64'd0;
      first = s == shot_lo[shot_head];
      last = shot_hi_known[shot_head] && s + size == shot_hi[shot_head];
      if (last) begin
         shot_head = (shot_head + 1) % SSLOTS;
         shot_cnt--;
      end
      slot = (rtok_head + rtok_cnt) % TSLOTS;
      rtok_start[slot] = s;
      rtok_size[slot] = size;
      rtok_done[slot] = 1'b0;
      rtok_cnt++;
      adv = size > ovl ? size - ovl : 64'd0;
      pos_rd = (pos_rd + adv) & PMASK;
      o.status = owbt_pkg::ST_OK;
      o.token_tag = TAGW'(slot);
      o.start_pos = POSW'(s);
      o.span_frames = FRW'(size);
      o.span_overlap = OVW'(ovl);
      o.is_shot_start = first;
      o.is_shot_end = last;
      return o;
   endfunction

   function automatic owbt_pkg::rsp_type predict_span(owbt_pkg::req_type r);
      owbt_pkg::rsp_type o;
      int                tag;
      o = '0;
      tag = int'(r.done_tag);
      case (r.func)
         owbt_pkg::FUNC_WRITE: o = grant_write(64'(r.write_frames), r.ends_shot, 1'b1);
         owbt_pkg::FUNC_READ:  o = grant_read();
         owbt_pkg::FUNC_WDONE: begin
            if ((tag + TSLOTS - wtok_head) % TSLOTS < wtok_cnt) wtok_done[tag] = 1'b1;
            while (wtok_cnt != 0 && wtok_done[wtok_head]) begin
               pos_wr_done = (pos_wr_done + wtok_size[wtok_head]) & PMASK;
               wtok_done[wtok_head] = 1'b0;
               wtok_head = (wtok_head + 1) % TSLOTS;
               wtok_cnt--;
            end
            o.token_tag = TAGW'(tag);
         end
         owbt_pkg::FUNC_RDONE: begin
            if ((tag + TSLOTS - rtok_head) % TSLOTS < rtok_cnt) rtok_done[tag] = 1'b1;
            while (rtok_cnt != 0 && rtok_done[rtok_head]) begin
               pos_rd_done = (rtok_start[rtok_head] + rtok_size[rtok_head]) & PMASK;
               rtok_done[rtok_head] = 1'b0;
               rtok_head = (rtok_head + 1) % TSLOTS;
               rtok_cnt--;
            end
            o.token_tag = TAGW'(tag);
         end
         owbt_pkg::FUNC_CLOSE: is_closed = 1'b1;
         default: ;
      endcase
      return o;
   endfunction

   task automatic check_field(string name, bit [63:0] e, bit [63:0] a);
      if (e !== a) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      end
   endtask

   always @(posedge clock) begin
      owbt_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (span_q.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, expected none, got %h", $time, rsp_data);
         end else begin
            e = span_q.pop_front();
            check_field("status", 64'(e.status), 64'(rsp_data.status));
            check_field("token_tag", 64'(e.token_tag), 64'(rsp_data.token_tag));
            check_field("start_pos", 64'(e.start_pos), 64'(rsp_data.start_pos));
            check_field("span_frames", 64'(e.span_frames), 64'(rsp_data.span_frames));
            check_field("span_overlap", 64'(e.span_overlap), 64'(rsp_data.span_overlap));
            check_field("is_shot_start", 64'(e.is_shot_start), 64'(rsp_data.is_shot_start));
            check_field("is_shot_end", 64'(e.is_shot_end), 64'(rsp_data.is_shot_end));
         end
      end
   end

   task automatic send_request(owbt_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      span_q.push_back(predict_span(r));
   endtask

   task automatic send_op(logic [2:0] f, int n, bit ends, int tag);
      owbt_pkg::req_type r;
      r.func = f;
      r.write_frames = FRW'(n);
      r.ends_shot = ends;
      r.done_tag = TAGW'(tag);
      send_request(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (span_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSRW-1:0] idx, int unsigned v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= FRW'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         owbt_pkg::CSR_BUFFER:  cfg_buffer = 64'(v & 32'h1F_FFFF);
         owbt_pkg::CSR_WINDOW:  cfg_window = 64'(v & 32'h1F_FFFF);
         owbt_pkg::CSR_OVERLAP: cfg_overlap = 64'(v & 32'hF_FFFF);
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned b, int unsigned w, int unsigned v);
      wait_idle();
      write_csr(owbt_pkg::CSR_BUFFER, b);
      write_csr(owbt_pkg::CSR_WINDOW, w);
      write_csr(owbt_pkg::CSR_OVERLAP, v);
      csr_valid <= 1'b0;
   endtask

   function automatic owbt_pkg::req_type pick_request(bit may_close);
      owbt_pkg::req_type r;
      int                sel, lim;
      r.func = owbt_pkg::FUNC_WRITE;
      r.write_frames = '0;
      r.ends_shot = ($urandom_range(2) == 0);
      r.done_tag = TAGW'($urandom_range(15));
      sel = $urandom_range(99);
      lim = cfg_buffer > 32 ? 32 : int'(cfg_buffer);
      if (sel < 36) begin
         sel = $urandom_range(99);
         if (sel < 80) r.write_frames = FRW'($urandom_range(lim));
         else if (sel < 90) r.write_frames = FRW'($urandom_range(int'(cfg_buffer)));
         else if (sel < 95) r.write_frames = FRW'(cfg_buffer + 1);
         else r.write_frames = FRW'($urandom);
         if (!may_close && grant_write(64'(r.write_frames), r.ends_shot, 1'b0).status ==
             owbt_pkg::ST_DEADLOCK)
            r.func = owbt_pkg::FUNC_READ;
      end else if (sel < 66) begin
         r.func = owbt_pkg::FUNC_READ;
      end else if (sel < 81) begin
         r.func = owbt_pkg::FUNC_WDONE;
         if (wtok_cnt != 0 && $urandom_range(9) != 0)
            r.done_tag = TAGW'((wtok_head + $urandom_range(wtok_cnt - 1)) % TSLOTS);
      end else if (sel < 96) begin
         r.func = owbt_pkg::FUNC_RDONE;
         if (rtok_cnt != 0 && $urandom_range(9) != 0)
            r.done_tag = TAGW'((rtok_head + $urandom_range(rtok_cnt - 1)) % TSLOTS);
      end else begin
         r.func = may_close ? 3'($urandom_range(4, 7)) : 3'($urandom_range(5, 7));
      end
      return r;
   endfunction

   task automatic run_random(int count, bit may_close);
      repeat (count) send_request(pick_request(may_close));
   endtask

   task automatic test_directed();
      send_op(owbt_pkg::FUNC_WRITE, 65, 0, 0);
      send_op(owbt_pkg::FUNC_WRITE, 0, 0, 15);
      send_op(owbt_pkg::FUNC_WRITE, 64, 1, 0);
      send_op(owbt_pkg::FUNC_READ, 0, 0, 0);
      send_op(owbt_pkg::FUNC_WDONE, 0, 0, 1);
      send_op(owbt_pkg::FUNC_WDONE, 0, 0, 9);
      send_op(owbt_pkg::FUNC_WDONE, 0, 0, 0);
      send_op(owbt_pkg::FUNC_READ, 0, 0, 0);
      send_op(owbt_pkg::FUNC_RDONE, 0, 0, 10);
      send_op(owbt_pkg::FUNC_RDONE, 0, 0, 0);
      send_op(3'd5, 0, 1, 15);
      send_op(3'd6, 1048575, 0, 0);
      send_op(3'd7, 0, 0, 5);
      send_op(owbt_pkg::FUNC_WRITE, 0, 1, 0);
      send_op(owbt_pkg::FUNC_WRITE, 1048576, 1, 0);
      send_op(owbt_pkg::FUNC_WRITE, 1048575, 0, 0);
      send_op(owbt_pkg::FUNC_READ, 0, 0, 0);
      send_op(owbt_pkg::FUNC_RDONE, 0, 0, 1);
      send_op(owbt_pkg::FUNC_WDONE, 0, 0, 2);
   endtask

   task automatic test_settings();
      int unsigned cfg[8][3] = '{
         '{64, 8, 3}, '{16, 5, 4}, '{1, 1, 0}, '{200, 17, 16},
         '{1048576, 1048576, 1048575}, '{64, 1, 0}, '{33, 40, 50}, '{128, 12, 0}};
      int unsigned idle[4][2] = '{'{0, 0}, '{82, 0}, '{0, 82}, '{24, 24}};
      for (int p = 0; p < 8; p++) begin
         configure(cfg[p][0], cfg[p][1], cfg[p][2]);
         send_idle_pct = idle[p % 4][0];
         stall_pct = idle[p % 4][1];
         run_random(100, 1'b0);
      end
   endtask

   task automatic test_backpressure();
      configure(64, 4, 1);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_len = 500;
      run_random(40, 1'b0);
      wait_idle();
      run_random(20, 1'b0);
   endtask

   task automatic test_deadlock();
      configure(64, 1048576, 0);
      for (int k = 0; k < 80 && !is_closed; k++) begin
         if (grant_write(64, 0, 1'b0).status == owbt_pkg::ST_DEADLOCK)
            send_op(owbt_pkg::FUNC_WRITE, 64, 0, 0);
         else if (wtok_cnt != 0) send_op(owbt_pkg::FUNC_WDONE, 0, 0, wtok_head);
         else if (rtok_cnt != 0) send_op(owbt_pkg::FUNC_RDONE, 0, 0, rtok_head);
         else if (frames_ready()) send_op(owbt_pkg::FUNC_READ, 0, 0, 0);
         else send_op(owbt_pkg::FUNC_WRITE, 64, 0, 0);
      end
   endtask

   task automatic test_close();
      configure(64, 8, 2);
      send_op(owbt_pkg::FUNC_CLOSE, 0, 0, 0);
      send_op(owbt_pkg::FUNC_WRITE, 4, 0, 0);
      send_op(owbt_pkg::FUNC_READ, 0, 0, 0);
      run_random(30, 1'b1);
   endtask

   initial begin
      cfg_buffer = 64;
      cfg_window = 1;
      cfg_overlap = 0;
      pos_wr = 0;
      pos_wr_done = 0;
      pos_rd = 0;
      pos_rd_done = 0;
      is_closed = 0;
      shot_head = 0;
      shot_cnt = 0;
      wtok_head = 0;
      wtok_cnt = 0;
      rtok_head = 0;
      rtok_cnt = 0;
      for (int i = 0; i < SSLOTS; i++) begin
         shot_lo[i] = 0;
         shot_hi[i] = 0;
         shot_hi_known[i] = 0;
      end
      for (int i = 0; i < TSLOTS; i++) begin
         wtok_done[i] = 0;
         rtok_done[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      test_backpressure();
      test_deadlock();
      test_close();
      wait_idle();
      if (errors == 0 && span_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
